@@ design/bsir_pkg.sv @@
// ---------------------------------------------------------------------------
// bsir_pkg: shared definitions for the byte set
// Capacity, counter widths, request and status codes, controller states and
// the control bundle that the controller broadcasts along the cell row.
// ---------------------------------------------------------------------------
package bsir_pkg;

  // Number of entries the set can hold (1 to 255).
  localparam int CAPACITY   = 128;
  // Width of the entry count, wide enough to hold CAPACITY itself.
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  // Field widths of the request and result beats.
  localparam int REQ_W      = 2;
  localparam int ELEM_W     = 8;
  localparam int STATUS_W   = 3;
  localparam int TOTAL_W    = 8;
  // Cells are grouped for the match reduction and the removal prefix.
  localparam int GROUP_SIZE = 8;
  localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_QUERY  = 2'd2
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_ADDED     = 3'd0,
    STS_ALREADY   = 3'd1,
    STS_FULL      = 3'd2,
    STS_REMOVED   = 3'd3,
    STS_NOT_FOUND = 3'd4,
    STS_PRESENT   = 3'd5,
    STS_ABSENT    = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_GRP,
    ST_SUM,
    ST_APPLY
  } state_e;

  // Control broadcast from the controller to every cell.
  typedef struct packed {
    logic              cmp_en;
    logic              shift_en;
    logic              load_en;
    logic [ELEM_W-1:0] key;
  } cell_ctl_t;

endpackage

@@ design/bsir_req_if.sv @@
// ---------------------------------------------------------------------------
// bsir_req_if: request channel
// Carries one request beat: the operation code and the byte it concerns.
// ---------------------------------------------------------------------------
interface bsir_req_if;
  logic                        valid;
  logic                        ready;
  logic [bsir_pkg::REQ_W-1:0]  req_type;
  logic [bsir_pkg::ELEM_W-1:0] element;

  modport source (output valid, output req_type, output element, input ready);
  modport sink   (input valid, input req_type, input element, output ready);
endinterface

@@ design/bsir_rsp_if.sv @@
// ---------------------------------------------------------------------------
// bsir_rsp_if: result channel
// Carries one result beat: the status code and the entry count.
// ---------------------------------------------------------------------------
interface bsir_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bsir_pkg::STATUS_W-1:0] status;
  logic [bsir_pkg::TOTAL_W-1:0]  entry_total;

  modport source (output valid, output status, output entry_total, input ready);
  modport sink   (input valid, input status, input entry_total, output ready);
endinterface

@@ design/bsir_cell.sv @@
// ---------------------------------------------------------------------------
// bsir_cell: one entry of the byte set
// Holds one byte, registers its own match against the broadcast key, passes
// the removal prefix on to the next cell and takes its neighbour's byte when
// an entry at or below it is removed.
// ---------------------------------------------------------------------------
module bsir_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bsir_pkg::cell_ctl_t         ctl_i,
  input  logic [bsir_pkg::CNT_W-1:0]  cnt_i,
  input  logic [bsir_pkg::CNT_W-1:0]  idx_i,
  input  logic [bsir_pkg::ELEM_W-1:0] nxt_data_i,
  input  logic                        seen_i,
  output logic [bsir_pkg::ELEM_W-1:0] data_o,
  output logic                        hit_o,
  output logic                        seen_o
);

  logic [bsir_pkg::ELEM_W-1:0] data_q, data_d;
  logic                        hit_q, hit_d;
  logic                        live;

  // The cell holds a valid entry only below the current count.
  assign live = (idx_i < cnt_i);

  // Match flag, captured once per request.
  always_comb begin
    hit_d = hit_q;
    if (ctl_i.cmp_en) begin
      hit_d = live && (data_q == ctl_i.key);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  // The removal prefix: true from the matching cell upwards.
  assign seen_o = seen_i | hit_q;

  // Byte storage: shift down on removal, load the key on insert at the tail.
  always_comb begin
    data_d = data_q;
    if (ctl_i.shift_en && seen_o) begin
      data_d = nxt_data_i;
    end else if (ctl_i.load_en && (idx_i == cnt_i)) begin
      data_d = ctl_i.key;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign hit_o  = hit_q;

endmodule

@@ design/bsir_ctrl.sv @@
// ---------------------------------------------------------------------------
// bsir_ctrl: request sequencer and entry counter
// Takes a request beat, steps the cell row through compare, group reduction
// and prefix, then applies the update and registers the result beat.
// ---------------------------------------------------------------------------
module bsir_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  bsir_req_if.sink                           req_i,
  bsir_rsp_if.source                         rsp_o,
  input  logic [bsir_pkg::CAPACITY-1:0]      hit_i,
  output bsir_pkg::cell_ctl_t                ctl_o,
  output logic [bsir_pkg::CNT_W-1:0]         cnt_o,
  output logic [bsir_pkg::NUM_GROUPS-1:0]    carry_o
);

  bsir_pkg::state_e                    state_q, state_d;
  logic [bsir_pkg::REQ_W-1:0]          op_q, op_d;
  logic [bsir_pkg::ELEM_W-1:0]         key_q, key_d;
  logic [bsir_pkg::CNT_W-1:0]          cnt_q, cnt_d;
  logic [bsir_pkg::NUM_GROUPS-1:0]     grp_any_q, grp_any_d;
  logic [bsir_pkg::NUM_GROUPS-1:0]     carry_q, carry_d;
  logic                                found_q, found_d;
  logic                                out_valid_q, out_valid_d;
  logic [bsir_pkg::STATUS_W-1:0]       status_q, status_d;
  logic [bsir_pkg::TOTAL_W-1:0]        total_q, total_d;
  logic [bsir_pkg::NUM_GROUPS-1:0]     grp_any_c;
  logic [bsir_pkg::NUM_GROUPS-1:0]     carry_c;
  logic                                found_c;
  logic                                apply_go;
  logic                                has_room;

  // OR of the match flags within each group of cells.
  always_comb begin
    grp_any_c = '0;
    for (int g = 0; g < bsir_pkg::NUM_GROUPS; g++) begin
      for (int k = 0; k < bsir_pkg::GROUP_SIZE; k++) begin
        if (g * bsir_pkg::GROUP_SIZE + k < bsir_pkg::CAPACITY) begin
          grp_any_c[g] = grp_any_c[g] | hit_i[g * bsir_pkg::GROUP_SIZE + k];
        end
      end
    end
  end

  // Carry into each group: a match somewhere in an earlier group.
  always_comb begin
    logic acc;
    acc     = 1'b0;
    carry_c = '0;
    for (int g = 0; g < bsir_pkg::NUM_GROUPS; g++) begin
      carry_c[g] = acc;
      acc        = acc | grp_any_q[g];
    end
    found_c = acc;
  end

  assign has_room = (cnt_q < bsir_pkg::CNT_W'(bsir_pkg::CAPACITY));
  // The result register must be free before an update is committed.
  assign apply_go = !out_valid_q || rsp_o.ready;

  // Next state, cell control and result.
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    key_d        = key_q;
    cnt_d        = cnt_q;
    grp_any_d    = grp_any_q;
    carry_d      = carry_q;
    found_d      = found_q;
    out_valid_d  = out_valid_q;
    status_d     = status_q;
    total_d      = total_q;
    req_i.ready  = 1'b0;
    ctl_o.cmp_en   = 1'b0;
    ctl_o.shift_en = 1'b0;
    ctl_o.load_en  = 1'b0;
    ctl_o.key      = key_q;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      bsir_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          op_d    = req_i.req_type;
          key_d   = req_i.element;
          state_d = bsir_pkg::ST_CMP;
        end
      end
      bsir_pkg::ST_CMP: begin
        ctl_o.cmp_en = 1'b1;
        state_d      = bsir_pkg::ST_GRP;
      end
      bsir_pkg::ST_GRP: begin
        grp_any_d = grp_any_c;
        state_d   = bsir_pkg::ST_SUM;
      end
      bsir_pkg::ST_SUM: begin
        carry_d = carry_c;
        found_d = found_c;
        state_d = bsir_pkg::ST_APPLY;
      end
      bsir_pkg::ST_APPLY: begin
        if (apply_go) begin
          case (op_q)
            bsir_pkg::REQ_INSERT: begin
              if (found_q) begin
                status_d = bsir_pkg::STS_ALREADY;
              end else if (has_room) begin
                status_d      = bsir_pkg::STS_ADDED;
                ctl_o.load_en = 1'b1;
                cnt_d         = cnt_q + 1'b1;
              end else begin
                status_d = bsir_pkg::STS_FULL;
              end
            end
            bsir_pkg::REQ_REMOVE: begin
              if (found_q) begin
                status_d       = bsir_pkg::STS_REMOVED;
                ctl_o.shift_en = 1'b1;
                cnt_d          = cnt_q - 1'b1;
              end else begin
                status_d = bsir_pkg::STS_NOT_FOUND;
              end
            end
            default: begin
              // Queries and the unused code only report presence.
              status_d = found_q ? bsir_pkg::STS_PRESENT : bsir_pkg::STS_ABSENT;
            end
          endcase
          total_d     = bsir_pkg::TOTAL_W'(cnt_d);
          out_valid_d = 1'b1;
          state_d     = bsir_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bsir_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bsir_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    grp_any_q <= grp_any_d;
    carry_q   <= carry_d;
    found_q   <= found_d;
    status_q  <= status_d;
    total_q   <= total_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.entry_total = total_q;
  assign cnt_o             = cnt_q;
  assign carry_o           = carry_q;

  // The count never passes the capacity.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= bsir_pkg::CNT_W'(bsir_pkg::CAPACITY))
    else $error("entry count above capacity");

  // Stored entries are distinct, so at most one cell matches.
  a_one_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_i))
    else $error("more than one cell matched the key");

  // A result beat appears only out of the apply step.
  a_rsp_from_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == bsir_pkg::ST_APPLY)
    else $error("result beat raised outside the apply step");

  // A successful insert grows the set by exactly one.
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bsir_pkg::ST_APPLY && apply_go && ctl_o.load_en)
    |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("insert did not grow the count by one");

  // The row only shifts when a matching entry was found.
  a_shift_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.shift_en |-> found_q && cnt_q != '0)
    else $error("shift without a matching entry");

endmodule

@@ design/byte_set_insert_remove.sv @@
// ---------------------------------------------------------------------------
// byte_set_insert_remove: insertion-ordered set of distinct bytes
// A row of compare-and-shift cells holds the entries in order; a small
// sequencer compares, reduces, and inserts at the tail or closes the gap.
// ---------------------------------------------------------------------------
//
//   channel  direction  beat contents
//   req_i    in         req_type (2 bits), element (8 bits)
//   rsp_o    out        status (3 bits), entry_total (8 bits)
//
// Each request passes through five steps: acceptance, the compare in every cell,
// the per-group match reduction, the group prefix and the update with the result
// register load, which also registers the result beat.
// Reset clears the entry count and the sequencer; the stored bytes need none.
// A stalled result holds the update step until the result register is free.
module byte_set_insert_remove (
  input  logic        clk_i,
  input  logic        rst_ni,
  bsir_req_if.sink    req_i,
  bsir_rsp_if.source  rsp_o
);

  bsir_pkg::cell_ctl_t                  ctl;
  logic [bsir_pkg::CNT_W-1:0]           cnt;
  logic [bsir_pkg::NUM_GROUPS-1:0]      carry;
  logic [bsir_pkg::CAPACITY-1:0]        hit;
  logic [bsir_pkg::CAPACITY-1:0]        seen;
  logic [bsir_pkg::CAPACITY-1:0]        seen_in;
  logic [bsir_pkg::ELEM_W-1:0]          data [bsir_pkg::CAPACITY];
  logic [bsir_pkg::ELEM_W-1:0]          nxt_data [bsir_pkg::CAPACITY];

  bsir_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .rsp_o   (rsp_o),
    .hit_i   (hit),
    .ctl_o   (ctl),
    .cnt_o   (cnt),
    .carry_o (carry)
  );

  // The cell row: the prefix ripples within a group and enters each group
  // from the registered carry; each cell but the last reads its upper neighbour's byte.
  for (genvar i = 0; i < bsir_pkg::CAPACITY; i++) begin : g_cell
    if (i % bsir_pkg::GROUP_SIZE == 0) begin : g_head
      assign seen_in[i] = carry[i / bsir_pkg::GROUP_SIZE];
    end else begin : g_body
      assign seen_in[i] = seen[i-1];
    end

    if (i == bsir_pkg::CAPACITY - 1) begin : g_last
      assign nxt_data[i] = data[i];
    end else begin : g_inner
      assign nxt_data[i] = data[i+1];
    end

    bsir_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .cnt_i      (cnt),
      .idx_i      (bsir_pkg::CNT_W'(i)),
      .nxt_data_i (nxt_data[i]),
      .seen_i     (seen_in[i]),
      .data_o     (data[i]),
      .hit_o      (hit[i]),
      .seen_o     (seen[i])
    );
  end

endmodule

@@ tb/sv/byte_set_insert_remove_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// byte_set_insert_remove_tb: self-checking bench for the byte set
// Drives insert, remove and query beats with random gaps, tracks the set
// contents in a scoreboard and compares every result beat with the status
// and entry count that the tracked set predicts. The random part fills the
// set to capacity, mixes operations and drains it again, several times over.
// ---------------------------------------------------------------------------
module byte_set_insert_remove_tb;

  localparam int IDLE_LIMIT      = 4000;
  localparam int PRESSURE_CYCLES = 400;
  localparam int RANDOM_ITEMS    = 1600;
  localparam int TAIL_CYCLES     = 20;

  // The request code without a meaning of its own; the block treats it as a query.
  localparam logic [bsir_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    bsir_pkg::status_e            status;
    logic [bsir_pkg::TOTAL_W-1:0] total;
  } result_t;

  typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} mix_e;

  // Scoreboard: keeps its own copy of the set and the results it predicts.
  class set_tracker;
    logic [bsir_pkg::ELEM_W-1:0] slots [bsir_pkg::CAPACITY];
    int                          fill_level;
    result_t                     awaited [$];
    int                          faults;

    function new();
      fill_level = 0;
      faults     = 0;
    endfunction

    function int slot_of(logic [bsir_pkg::ELEM_W-1:0] b);
      for (int i = 0; i < fill_level; i++) begin
        if (slots[i] == b) return i;
      end
      return -1;
    endfunction

    // Applies an accepted request to the tracked set and queues its result.
    function void note_request(logic [bsir_pkg::REQ_W-1:0] op,
                               logic [bsir_pkg::ELEM_W-1:0] b);
      int      pos;
      result_t r;
      pos = slot_of(b);
      if (op == bsir_pkg::REQ_INSERT) begin
        if (pos >= 0) begin
          r.status = bsir_pkg::STS_ALREADY;
        end else if (fill_level < bsir_pkg::CAPACITY) begin
          slots[fill_level] = b;
          fill_level++;
          r.status = bsir_pkg::STS_ADDED;
        end else begin
          r.status = bsir_pkg::STS_FULL;
        end
      end else if (op == bsir_pkg::REQ_REMOVE) begin
        if (pos >= 0) begin
          // Later entries move down one place, keeping their order.
          for (int j = pos; j + 1 < fill_level; j++) slots[j] = slots[j + 1];
          fill_level--;
          r.status = bsir_pkg::STS_REMOVED;
        end else begin
          r.status = bsir_pkg::STS_NOT_FOUND;
        end
      end else begin
        // The unused request code behaves as a query.
        r.status = (pos >= 0) ? bsir_pkg::STS_PRESENT : bsir_pkg::STS_ABSENT;
      end
      r.total = bsir_pkg::TOTAL_W'(fill_level);
      awaited.push_back(r);
    endfunction

    // Compares a result beat with the oldest prediction.
    function void check_result(logic [bsir_pkg::STATUS_W-1:0] st,
                               logic [bsir_pkg::TOTAL_W-1:0] tot);
      result_t r;
      if (awaited.size() == 0) begin
        $display("%0t: result beat with nothing expected: status %0d total %0d",
                 $time, st, tot);
        faults++;
        return;
      end
      r = awaited.pop_front();
      if (st !== r.status) begin
        $display("%0t: status mismatch: expected %0d (%s), actual %0d",
                 $time, r.status, r.status.name(), st);
        faults++;
      end
      if (tot !== r.total) begin
        $display("%0t: entry_total mismatch: expected %0d, actual %0d",
                 $time, r.total, tot);
        faults++;
      end
    endfunction

    function logic [bsir_pkg::ELEM_W-1:0] pick_stored();
      return slots[$urandom_range(0, fill_level - 1)];
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   idle_cycles;
  int   sent_items;
  bit   pressure_wanted;
  bit   pressure_done;

  bsir_req_if req_if ();
  bsir_rsp_if rsp_if ();

  set_tracker board = new();

  byte_set_insert_remove DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Clock with a 2 ns period.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Idle lengths: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offers one request beat and returns at the edge where it is taken.
  task automatic send_request(input logic [bsir_pkg::REQ_W-1:0] op,
                              input logic [bsir_pkg::ELEM_W-1:0] b,
                              input bit no_gaps);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= op;
    req_if.element  <= b;
    do @(posedge clk); while (!req_if.ready);
    sent_items++;
  endtask

  // Chooses one random request according to the current mix.
  task automatic send_random(input mix_e mix, input bit no_gaps);
    int                          roll;
    logic [bsir_pkg::REQ_W-1:0]  op;
    logic [bsir_pkg::ELEM_W-1:0] b;
    roll = $urandom_range(0, 99);
    b    = bsir_pkg::ELEM_W'($urandom_range(0, 255));
    case (mix)
      MIX_FILL: begin
        op = (roll < 85) ? bsir_pkg::REQ_INSERT :
             (roll < 92) ? bsir_pkg::REQ_REMOVE : bsir_pkg::REQ_QUERY;
      end
      MIX_BALANCED: begin
        op = (roll < 34) ? bsir_pkg::REQ_INSERT :
             (roll < 67) ? bsir_pkg::REQ_REMOVE : bsir_pkg::REQ_QUERY;
      end
      default: begin
        op = (roll < 10) ? bsir_pkg::REQ_INSERT :
             (roll < 85) ? bsir_pkg::REQ_REMOVE : bsir_pkg::REQ_QUERY;
      end
    endcase
    // Removes and queries mostly aim at bytes that are held.
    if (op != bsir_pkg::REQ_INSERT && board.fill_level > 0 &&
        $urandom_range(0, 99) < 75) begin
      b = board.pick_stored();
    end
    // The unused request code stands in for a query now and then.
    if (op == bsir_pkg::REQ_QUERY && $urandom_range(0, 3) == 0) op = REQ_UNUSED;
    send_request(op, b, no_gaps);
  endtask

  // Beat monitors feed the scoreboard.
  always @(posedge clk) begin
    if (rst_n && req_if.valid && req_if.ready) begin
      board.note_request(req_if.req_type, req_if.element);
    end
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      board.check_result(rsp_if.status, rsp_if.entry_total);
    end
  end

  // Watchdog on cycles in which no beat moves.
  always @(posedge clk) begin
    if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("byte_set_insert_remove_tb NOT OK");
      $finish;
    end
  end

  // Result side: random ready pattern plus one long hold-off.
  initial begin
    int hold;
    rsp_if.ready <= 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (pressure_wanted && !pressure_done) begin
        pressure_done = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (PRESSURE_CYCLES) @(posedge clk);
      end
      hold = pick_gap();
      if (hold > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Reset, directed requests, random requests, then drain and report.
  initial begin
    mix_e mix;
    int   block_len;
    bit   no_gaps;
    int   block_no;
    sent_items      = 0;
    pressure_wanted = 1'b0;
    rst_n           <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.req_type <= bsir_pkg::REQ_INSERT;
    req_if.element  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty set, extremes of the byte, duplicates, the unused
    // code, removal from the middle, head and tail, and back to empty.
    send_request(bsir_pkg::REQ_QUERY,  8'h00, 1'b0);
    send_request(bsir_pkg::REQ_REMOVE, 8'h55, 1'b0);
    send_request(bsir_pkg::REQ_INSERT, 8'h00, 1'b0);
    send_request(bsir_pkg::REQ_INSERT, 8'hFF, 1'b0);
    send_request(bsir_pkg::REQ_INSERT, 8'h00, 1'b0);
    send_request(bsir_pkg::REQ_INSERT, 8'hAA, 1'b0);
    send_request(bsir_pkg::REQ_INSERT, 8'h55, 1'b0);
    send_request(bsir_pkg::REQ_QUERY,  8'hFF, 1'b0);
    send_request(REQ_UNUSED,           8'hFF, 1'b0);
    send_request(REQ_UNUSED,           8'h12, 1'b0);
    send_request(bsir_pkg::REQ_REMOVE, 8'hFF, 1'b0);
    send_request(bsir_pkg::REQ_QUERY,  8'h55, 1'b0);
    send_request(bsir_pkg::REQ_REMOVE, 8'hFF, 1'b0);
    send_request(bsir_pkg::REQ_REMOVE, 8'h00, 1'b0);
    send_request(bsir_pkg::REQ_REMOVE, 8'h55, 1'b0);
    send_request(bsir_pkg::REQ_QUERY,  8'hAA, 1'b0);
    send_request(bsir_pkg::REQ_REMOVE, 8'hAA, 1'b0);
    send_request(bsir_pkg::REQ_QUERY,  8'hAA, 1'b0);
    send_request(bsir_pkg::REQ_INSERT, 8'hFF, 1'b0);

    // Random: fill to capacity and beyond, mix, drain, and repeat.
    block_no = 0;
    while (sent_items < RANDOM_ITEMS) begin
      mix       = mix_e'(block_no % 3);
      block_len = (mix == MIX_FILL) ? 300 : (mix == MIX_BALANCED) ? 150 : 200;
      no_gaps   = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < block_len; k++) begin
        if (sent_items == RANDOM_ITEMS / 2) pressure_wanted = 1'b1;
        send_random(mix, no_gaps);
      end
      block_no++;
    end
    req_if.valid <= 1'b0;

    while (board.awaited.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.faults == 0) begin
      $display("byte_set_insert_remove_tb OK");
    end else begin
      $display("byte_set_insert_remove_tb NOT OK");
    end
    $finish;
  end

endmodule
